// File: rtl/s58tr_pkg.sv
// Shared types, constants and the 5x8 font ROM for the scaled text renderer.
package s58tr_pkg;

   localparam int unsigned COORD_BITS = 16;
   localparam int unsigned GLYPH_COLS = 5;
   localparam int unsigned GLYPH_ROWS = 8;
   localparam int unsigned GLYPH_DOTS = GLYPH_COLS * GLYPH_ROWS;

   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_LF = 8'h0A;

   localparam logic REQ_START = 1'b0;
   localparam logic REQ_CHAR  = 1'b1;

   localparam logic [2:0] CSR_DOT_WIDTH   = 3'd0;
   localparam logic [2:0] CSR_DOT_HEIGHT  = 3'd1;
   localparam logic [2:0] CSR_DOT_GAP_X   = 3'd2;
   localparam logic [2:0] CSR_DOT_GAP_Y   = 3'd3;
   localparam logic [2:0] CSR_GLYPH_GAP_X = 3'd4;
   localparam logic [2:0] CSR_GLYPH_GAP_Y = 3'd5;

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic [GLYPH_DOTS-1:0] glyph_type;

   typedef struct packed {
      logic               req_type;
      logic signed [15:0] origin_x;
      logic signed [15:0] origin_y;
      logic [31:0]        text_color;
      logic [7:0]         char_code;
   } req_item_type;

   typedef struct packed {
      logic signed [15:0] rect_x;
      logic signed [15:0] rect_y;
      logic [31:0]        rect_color;
      logic               last_of_char;
   } rsp_item_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_origin;
      logic line_break;
      logic load_glyph;
      logic step;
      logic advance;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free;
      logic scan_last;
   } status_type;

   // Dot pattern of a character, row 0 in the top bits, leftmost column first.
   // Bytes without a pattern fall back to the question mark.
   function automatic glyph_type glyph_bits(input logic [7:0] code);
      glyph_type g;
      case (code)
         8'h20: g = {5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,5'h00};
         8'h2C: g = {5'h00,5'h00,5'h00,5'h00,5'h00,5'h06,5'h02,5'h04};
         8'h3B: g = {5'h00,5'h00,5'h06,5'h06,5'h00,5'h06,5'h02,5'h04};
         8'h2E: g = {5'h00,5'h00,5'h00,5'h00,5'h00,5'h06,5'h06,5'h00};
         8'h3A: g = {5'h00,5'h06,5'h06,5'h00,5'h06,5'h06,5'h00,5'h00};
         8'h2A: g = {5'h00,5'h04,5'h15,5'h0E,5'h15,5'h04,5'h00,5'h00};
         8'h7E: g = {5'h00,5'h08,5'h15,5'h02,5'h00,5'h00,5'h00,5'h00};
         8'h5E: g = {5'h04,5'h0A,5'h11,5'h00,5'h00,5'h00,5'h00,5'h00};
         8'h22: g = {5'h0A,5'h0A,5'h00,5'h00,5'h00,5'h00,5'h00,5'h00};
         8'h27: g = {5'h04,5'h04,5'h00,5'h00,5'h00,5'h00,5'h00,5'h00};
         8'h5C: g = {5'h00,5'h10,5'h08,5'h04,5'h02,5'h00,5'h00,5'h00};
         8'h2F: g = {5'h00,5'h02,5'h04,5'h08,5'h10,5'h00,5'h00,5'h00};
         8'h23: g = {5'h0A,5'h0A,5'h1F,5'h0A,5'h1F,5'h0A,5'h0A,5'h00};
         8'h21: g = {5'h04,5'h04,5'h04,5'h04,5'h00,5'h04,5'h04,5'h00};
         8'h5F: g = {5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,5'h1F,5'h00};
         8'h24: g = {5'h04,5'h0F,5'h14,5'h0E,5'h05,5'h1E,5'h04,5'h00};
         8'h25: g = {5'h18,5'h19,5'h02,5'h04,5'h08,5'h13,5'h03,5'h00};
         8'h26: g = {5'h08,5'h14,5'h14,5'h08,5'h15,5'h12,5'h0D,5'h00};
         8'h40: g = {5'h0E,5'h11,5'h15,5'h17,5'h14,5'h10,5'h0F,5'h00};
         8'h3C: g = {5'h02,5'h04,5'h08,5'h10,5'h08,5'h04,5'h02,5'h00};
         8'h3E: g = {5'h08,5'h04,5'h02,5'h01,5'h02,5'h04,5'h08,5'h00};
         8'h7C: g = {5'h04,5'h04,5'h04,5'h04,5'h04,5'h04,5'h04,5'h00};
         8'h3D: g = {5'h00,5'h00,5'h1F,5'h00,5'h1F,5'h00,5'h00,5'h00};
         8'h2B: g = {5'h00,5'h04,5'h04,5'h1F,5'h04,5'h04,5'h00,5'h00};
         8'h2D: g = {5'h00,5'h00,5'h00,5'h1F,5'h00,5'h00,5'h00,5'h00};
         8'h5B: g = {5'h06,5'h04,5'h04,5'h04,5'h04,5'h04,5'h06,5'h00};
         8'h5D: g = {5'h0C,5'h04,5'h04,5'h04,5'h04,5'h04,5'h0C,5'h00};
         8'h28: g = {5'h02,5'h04,5'h08,5'h08,5'h08,5'h04,5'h02,5'h00};
         8'h29: g = {5'h08,5'h04,5'h02,5'h02,5'h02,5'h04,5'h08,5'h00};
         8'h7B: g = {5'h03,5'h04,5'h04,5'h08,5'h04,5'h04,5'h03,5'h00};
         8'h7D: g = {5'h18,5'h04,5'h04,5'h02,5'h04,5'h04,5'h18,5'h00};
         8'h30: g = {5'h0E,5'h11,5'h11,5'h15,5'h11,5'h11,5'h0E,5'h00};
         8'h31: g = {5'h04,5'h0C,5'h04,5'h04,5'h04,5'h04,5'h0E,5'h00};
         8'h32: g = {5'h06,5'h09,5'h01,5'h02,5'h04,5'h08,5'h1F,5'h00};
         8'h33: g = {5'h1F,5'h02,5'h04,5'h02,5'h01,5'h11,5'h0E,5'h00};
         8'h34: g = {5'h02,5'h06,5'h0A,5'h12,5'h1F,5'h02,5'h02,5'h00};
         8'h35: g = {5'h1F,5'h10,5'h1E,5'h01,5'h01,5'h11,5'h0E,5'h00};
         8'h36: g = {5'h06,5'h08,5'h10,5'h1E,5'h11,5'h11,5'h0E,5'h00};
         8'h37: g = {5'h1F,5'h01,5'h02,5'h04,5'h08,5'h08,5'h08,5'h00};
         8'h38: g = {5'h0E,5'h11,5'h11,5'h0E,5'h11,5'h11,5'h0E,5'h00};
         8'h39: g = {5'h0E,5'h11,5'h11,5'h0F,5'h01,5'h02,5'h0C,5'h00};
         8'h41: g = {5'h0E,5'h11,5'h11,5'h1F,5'h11,5'h11,5'h11,5'h00};
         8'h42: g = {5'h1E,5'h11,5'h11,5'h1E,5'h11,5'h11,5'h1E,5'h00};
         8'h43: g = {5'h0E,5'h11,5'h10,5'h10,5'h10,5'h11,5'h0E,5'h00};
         8'h44: g = {5'h1E,5'h11,5'h11,5'h11,5'h11,5'h11,5'h1E,5'h00};
         8'h45: g = {5'h1F,5'h10,5'h10,5'h1E,5'h10,5'h10,5'h1F,5'h00};
         8'h46: g = {5'h1F,5'h10,5'h10,5'h1E,5'h10,5'h10,5'h10,5'h00};
         8'h47: g = {5'h0E,5'h11,5'h10,5'h17,5'h11,5'h11,5'h0E,5'h00};
         8'h48: g = {5'h11,5'h11,5'h11,5'h1F,5'h11,5'h11,5'h11,5'h00};
         8'h49: g = {5'h0E,5'h04,5'h04,5'h04,5'h04,5'h04,5'h0E,5'h00};
         8'h4A: g = {5'h07,5'h02,5'h02,5'h02,5'h02,5'h12,5'h0C,5'h00};
         8'h4B: g = {5'h11,5'h12,5'h14,5'h18,5'h14,5'h12,5'h11,5'h00};
         8'h4C: g = {5'h10,5'h10,5'h10,5'h10,5'h10,5'h10,5'h1F,5'h00};
         8'h4D: g = {5'h11,5'h1B,5'h15,5'h11,5'h11,5'h11,5'h11,5'h00};
         8'h4E: g = {5'h11,5'h19,5'h15,5'h13,5'h11,5'h11,5'h11,5'h00};
         8'h4F: g = {5'h0E,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E,5'h00};
         8'h50: g = {5'h1E,5'h11,5'h11,5'h1E,5'h10,5'h10,5'h10,5'h00};
         8'h51: g = {5'h0E,5'h11,5'h11,5'h11,5'h15,5'h12,5'h0D,5'h00};
         8'h52: g = {5'h1E,5'h11,5'h11,5'h1E,5'h14,5'h12,5'h11,5'h00};
         8'h53: g = {5'h0F,5'h10,5'h10,5'h0E,5'h01,5'h01,5'h1E,5'h00};
         8'h54: g = {5'h1F,5'h04,5'h04,5'h04,5'h04,5'h04,5'h04,5'h00};
         8'h55: g = {5'h11,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E,5'h00};
         8'h56: g = {5'h11,5'h11,5'h11,5'h11,5'h11,5'h0A,5'h04,5'h00};
         8'h57: g = {5'h11,5'h11,5'h11,5'h15,5'h15,5'h15,5'h0A,5'h00};
         8'h58: g = {5'h11,5'h11,5'h0A,5'h04,5'h0A,5'h11,5'h11,5'h00};
         8'h59: g = {5'h11,5'h11,5'h11,5'h0A,5'h04,5'h04,5'h04,5'h00};
         8'h5A: g = {5'h1F,5'h01,5'h02,5'h04,5'h08,5'h10,5'h1F,5'h00};
         8'h61: g = {5'h00,5'h00,5'h0E,5'h01,5'h0F,5'h11,5'h0F,5'h00};
         8'h62: g = {5'h10,5'h10,5'h16,5'h19,5'h11,5'h11,5'h1E,5'h00};
         8'h63: g = {5'h00,5'h00,5'h0E,5'h10,5'h10,5'h11,5'h0E,5'h00};
         8'h64: g = {5'h01,5'h01,5'h0D,5'h13,5'h11,5'h11,5'h0F,5'h00};
         8'h65: g = {5'h00,5'h00,5'h0E,5'h11,5'h1F,5'h10,5'h0E,5'h00};
         8'h66: g = {5'h06,5'h09,5'h08,5'h1C,5'h08,5'h08,5'h08,5'h00};
         8'h67: g = {5'h00,5'h00,5'h0E,5'h11,5'h11,5'h0F,5'h01,5'h0E};
         8'h68: g = {5'h10,5'h10,5'h16,5'h19,5'h11,5'h11,5'h11,5'h00};
         8'h69: g = {5'h04,5'h00,5'h0C,5'h04,5'h04,5'h04,5'h0E,5'h00};
         8'h6A: g = {5'h01,5'h00,5'h03,5'h01,5'h01,5'h01,5'h12,5'h0C};
         8'h6B: g = {5'h08,5'h08,5'h09,5'h0A,5'h0C,5'h0A,5'h09,5'h00};
         8'h6C: g = {5'h0C,5'h04,5'h04,5'h04,5'h04,5'h04,5'h0E,5'h00};
         8'h6D: g = {5'h00,5'h00,5'h1A,5'h15,5'h15,5'h11,5'h11,5'h00};
         8'h6E: g = {5'h00,5'h00,5'h16,5'h19,5'h11,5'h11,5'h11,5'h00};
         8'h6F: g = {5'h00,5'h00,5'h0E,5'h11,5'h11,5'h11,5'h0E,5'h00};
         8'h70: g = {5'h00,5'h00,5'h1E,5'h11,5'h11,5'h1E,5'h10,5'h10};
         8'h71: g = {5'h00,5'h00,5'h0D,5'h13,5'h11,5'h0F,5'h01,5'h01};
         8'h72: g = {5'h00,5'h00,5'h16,5'h19,5'h10,5'h10,5'h10,5'h00};
         8'h73: g = {5'h00,5'h00,5'h0E,5'h10,5'h0E,5'h01,5'h1E,5'h00};
         8'h74: g = {5'h08,5'h08,5'h1C,5'h08,5'h08,5'h09,5'h06,5'h00};
         8'h75: g = {5'h00,5'h00,5'h11,5'h11,5'h11,5'h13,5'h0D,5'h00};
         8'h76: g = {5'h00,5'h00,5'h11,5'h11,5'h11,5'h0A,5'h04,5'h00};
         8'h77: g = {5'h00,5'h00,5'h11,5'h11,5'h15,5'h15,5'h0A,5'h00};
         8'h78: g = {5'h00,5'h00,5'h11,5'h0A,5'h04,5'h0A,5'h11,5'h00};
         8'h79: g = {5'h00,5'h00,5'h11,5'h11,5'h11,5'h0F,5'h01,5'h0E};
         8'h7A: g = {5'h00,5'h00,5'h1F,5'h02,5'h04,5'h08,5'h1F,5'h00};
         default: g = {5'h0E,5'h11,5'h01,5'h02,5'h04,5'h00,5'h04,5'h00};
      endcase
      return g;
   endfunction

endpackage

// File: rtl/scaled_5x8_text_renderer.sv
// Top level of the scaled 5x8 dot-font text renderer.
//
// Usage: send a start transaction (req_type 0) with the text origin and color,
// then one transaction per character byte. Each lit dot of a glyph comes out
// on the rsp channel as one rectangle (left, top, color); last_of_char marks
// the final rectangle of a character. CR and LF return the cursor to the line
// start and move down one line; they and start transactions give no results.
// Dot size and spacing come from six 4-bit registers written over the csr
// port, which is always ready; write them only while the block is idle.
// A character is accepted, then the scanner walks all 40 dot positions of the
// glyph at one per cycle while the result register can take a dot. A rectangle
// is registered and appears on rsp in the cycle after its dot is scanned.
// req_stall stays high while a character is being scanned.
// When the receiver stalls, the result register holds and the scan pauses
// until it is taken. Reset restores the register defaults, clears the cursor,
// origin and color to zero and empties the result register.
module scaled_5x8_text_renderer (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  s58tr_pkg::req_item_type req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output s58tr_pkg::rsp_item_type rsp_data,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [2:0]              csr_index,
   input  logic [3:0]              csr_data
);

   s58tr_pkg::cmd_type    cmd;
   s58tr_pkg::status_type status;

   assign csr_ready = 1'b1;

   s58tr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .status    (status),
      .cmd       (cmd)
   );

   s58tr_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// File: rtl/s58tr_datapath.sv
// Datapath: configuration registers, cursor state, dot scanner and result register.
module s58tr_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  s58tr_pkg::req_item_type req_data,
   input  logic                    csr_write,
   input  logic [2:0]              csr_index,
   input  logic [3:0]              csr_data,
   input  s58tr_pkg::cmd_type      cmd,
   output s58tr_pkg::status_type   status,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output s58tr_pkg::rsp_item_type rsp_data
);

   logic [3:0] dot_width_ff, dot_height_ff, dot_gap_x_ff, dot_gap_y_ff;
   logic [3:0] glyph_gap_x_ff, glyph_gap_y_ff;

   s58tr_pkg::coord_type line_start_x_ff, line_start_x_in;
   s58tr_pkg::coord_type cursor_x_ff, cursor_x_in;
   s58tr_pkg::coord_type cursor_y_ff, cursor_y_in;
   logic [31:0]          color_ff, color_in;

   s58tr_pkg::glyph_type bits_ff, bits_in;
   logic [2:0]           col_ff, col_in;
   logic [2:0]           row_ff, row_in;
   logic [6:0]           x_off_ff, x_off_in;
   logic [7:0]           y_off_ff, y_off_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   s58tr_pkg::rsp_item_type rsp_ff, rsp_in;

   logic [4:0]           cx, cy;
   logic [7:0]           glyph_adv, line_adv;
   logic [31:0]          origin_x_wide, origin_y_wide;
   s58tr_pkg::coord_type dot_x, dot_y;
   logic [31:0]          dot_x_wide, dot_y_wide;
   logic                 lit, last_lit, row_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         dot_width_ff   <= 4'd1;
         dot_height_ff  <= 4'd1;
         dot_gap_x_ff   <= 4'd0;
         dot_gap_y_ff   <= 4'd0;
         glyph_gap_x_ff <= 4'd1;
         glyph_gap_y_ff <= 4'd1;
      end else if (csr_write) begin
         case (csr_index)
            s58tr_pkg::CSR_DOT_WIDTH:   dot_width_ff   <= csr_data;
            s58tr_pkg::CSR_DOT_HEIGHT:  dot_height_ff  <= csr_data;
            s58tr_pkg::CSR_DOT_GAP_X:   dot_gap_x_ff   <= csr_data;
            s58tr_pkg::CSR_DOT_GAP_Y:   dot_gap_y_ff   <= csr_data;
            s58tr_pkg::CSR_GLYPH_GAP_X: glyph_gap_x_ff <= csr_data;
            s58tr_pkg::CSR_GLYPH_GAP_Y: glyph_gap_y_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // A dot size of zero draws as one pixel.
   assign cx = {1'b0, (dot_width_ff == 4'd0) ? 4'd1 : dot_width_ff} + {1'b0, dot_gap_x_ff};
   assign cy = {1'b0, (dot_height_ff == 4'd0) ? 4'd1 : dot_height_ff} + {1'b0, dot_gap_y_ff};
   assign glyph_adv = ({3'b0, cx} << 2) + {3'b0, cx} + {4'b0, glyph_gap_x_ff};
   assign line_adv  = ({3'b0, cy} << 3) + {4'b0, glyph_gap_y_ff};

   assign origin_x_wide = 32'(req_data.origin_x);
   assign origin_y_wide = 32'(req_data.origin_y);

   assign dot_x      = cursor_x_ff + s58tr_pkg::COORD_BITS'(x_off_ff);
   assign dot_y      = cursor_y_ff + s58tr_pkg::COORD_BITS'(y_off_ff);
   assign dot_x_wide = 32'(dot_x);
   assign dot_y_wide = 32'(dot_y);

   assign lit      = bits_ff[s58tr_pkg::GLYPH_DOTS-1];
   assign last_lit = (bits_ff[s58tr_pkg::GLYPH_DOTS-2:0] == '0);
   assign row_end  = (col_ff == 3'(s58tr_pkg::GLYPH_COLS - 1));

   always_comb begin
      line_start_x_in = line_start_x_ff;
      cursor_x_in     = cursor_x_ff;
      cursor_y_in     = cursor_y_ff;
      color_in        = color_ff;
      bits_in         = bits_ff;
      col_in          = col_ff;
      row_in          = row_ff;
      x_off_in        = x_off_ff;
      y_off_in        = y_off_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_in          = rsp_ff;

      if (cmd.load_origin) begin
         line_start_x_in = origin_x_wide[s58tr_pkg::COORD_BITS-1:0];
         cursor_x_in     = origin_x_wide[s58tr_pkg::COORD_BITS-1:0];
         cursor_y_in     = origin_y_wide[s58tr_pkg::COORD_BITS-1:0];
         color_in        = req_data.text_color;
      end
      if (cmd.line_break) begin
         cursor_x_in = line_start_x_ff;
         cursor_y_in = cursor_y_ff + s58tr_pkg::COORD_BITS'(line_adv);
      end
      if (cmd.load_glyph) begin
         bits_in  = s58tr_pkg::glyph_bits(req_data.char_code);
         col_in   = 3'd0;
         row_in   = 3'd0;
         x_off_in = 7'd0;
         y_off_in = 8'd0;
      end
      if (cmd.step) begin
         bits_in = bits_ff << 1;
         if (row_end) begin
            col_in   = 3'd0;
            row_in   = row_ff + 3'd1;
            x_off_in = 7'd0;
            y_off_in = y_off_ff + {3'b0, cy};
         end else begin
            col_in   = col_ff + 3'd1;
            x_off_in = x_off_ff + {2'b0, cx};
         end
         if (lit) begin
            rsp_valid_in        = 1'b1;
            rsp_in.rect_x       = dot_x_wide[15:0];
            rsp_in.rect_y       = dot_y_wide[15:0];
            rsp_in.rect_color   = color_ff;
            rsp_in.last_of_char = last_lit;
         end
      end
      if (cmd.advance) begin
         cursor_x_in = cursor_x_ff + s58tr_pkg::COORD_BITS'(glyph_adv);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_start_x_ff <= '0;
         cursor_x_ff     <= '0;
         cursor_y_ff     <= '0;
         color_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         line_start_x_ff <= line_start_x_in;
         cursor_x_ff     <= cursor_x_in;
         cursor_y_ff     <= cursor_y_in;
         color_ff        <= color_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      bits_ff  <= bits_in;
      col_ff   <= col_in;
      row_ff   <= row_in;
      x_off_ff <= x_off_in;
      y_off_ff <= y_off_in;
      rsp_ff   <= rsp_in;
   end

   // The result register can take a new dot when empty or when its transaction completes.
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;
   assign status.scan_last = row_end && (row_ff == 3'(s58tr_pkg::GLYPH_ROWS - 1));

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: rtl/s58tr_ctrl.sv
// Controller: decodes each request and sequences the dot scan of a character.
module s58tr_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  s58tr_pkg::req_item_type req_data,
   input  s58tr_pkg::status_type   status,
   output s58tr_pkg::cmd_type      cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   state_type state_ff, state_in;
   logic      accept, is_break;

   assign accept   = req_valid && (state_ff == ST_IDLE);
   assign is_break = (req_data.char_code == s58tr_pkg::CHAR_CR) ||
                     (req_data.char_code == s58tr_pkg::CHAR_LF);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.req_type == s58tr_pkg::REQ_START) begin
                  cmd.load_origin = 1'b1;
               end else if (is_break) begin
                  cmd.line_break = 1'b1;
               end else begin
                  cmd.load_glyph = 1'b1;
                  state_in       = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // One dot position per cycle, held back while the result register holds a stalled rectangle.
            if (status.out_free) begin
               cmd.step = 1'b1;
               if (status.scan_last) begin
                  cmd.advance = 1'b1;
                  state_in    = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

// File: test/s58tr_rect_checker.sv
// Checker for the scaled 5x8 text renderer: predicts every dot rectangle and compares.
module s58tr_rect_checker (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_stall,
   input  s58tr_pkg::req_item_type req_data,
   input  logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  s58tr_pkg::rsp_item_type rsp_data,
   input  logic                    csr_valid,
   input  logic                    csr_ready,
   input  logic [2:0]              csr_index,
   input  logic [3:0]              csr_data,
   output int                      rects_pending,
   output int                      failures
);

   localparam int MAX_REPORTS = 10;

   logic [3:0] dot_w, dot_h, dot_gx, dot_gy, glyph_gx, glyph_gy;
   s58tr_pkg::coord_type line_x, pen_x, pen_y;
   logic [31:0] ink;

   // One byte per glyph row, row 0 in the top byte, leftmost dot in bit 4.
   logic [63:0] font_rows [0:255];

   s58tr_pkg::rsp_item_type awaited_rects [$];
   int mismatch_count = 0;

   task automatic add_glyph(input logic [7:0] code, input logic [63:0] rows);
      font_rows[code] = rows;
   endtask

   initial begin
      // Every byte without a pattern of its own is drawn as a question mark.
      for (int k = 0; k < 256; k++) font_rows[k] = 64'h0E_11_01_02_04_00_04_00;
      add_glyph(" ", 64'h00_00_00_00_00_00_00_00);
      add_glyph(",", 64'h00_00_00_00_00_06_02_04);
      add_glyph(";", 64'h00_00_06_06_00_06_02_04);
      add_glyph(".", 64'h00_00_00_00_00_06_06_00);
      add_glyph(":", 64'h00_06_06_00_06_06_00_00);
      add_glyph("*", 64'h00_04_15_0E_15_04_00_00);
      add_glyph("~", 64'h00_08_15_02_00_00_00_00);
      add_glyph("^", 64'h04_0A_11_00_00_00_00_00);
      add_glyph(8'h22, 64'h0A_0A_00_00_00_00_00_00);
      add_glyph(8'h27, 64'h04_04_00_00_00_00_00_00);
      add_glyph(8'h5C, 64'h00_10_08_04_02_00_00_00);
      add_glyph("/", 64'h00_02_04_08_10_00_00_00);
      add_glyph("#", 64'h0A_0A_1F_0A_1F_0A_0A_00);
      add_glyph("!", 64'h04_04_04_04_00_04_04_00);
      add_glyph("?", 64'h0E_11_01_02_04_00_04_00);
      add_glyph("_", 64'h00_00_00_00_00_00_1F_00);
      add_glyph("$", 64'h04_0F_14_0E_05_1E_04_00);
      add_glyph("%", 64'h18_19_02_04_08_13_03_00);
      add_glyph("&", 64'h08_14_14_08_15_12_0D_00);
      add_glyph("@", 64'h0E_11_15_17_14_10_0F_00);
      add_glyph("<", 64'h02_04_08_10_08_04_02_00);
      add_glyph(">", 64'h08_04_02_01_02_04_08_00);
      add_glyph("|", 64'h04_04_04_04_04_04_04_00);
      add_glyph("=", 64'h00_00_1F_00_1F_00_00_00);
      add_glyph("+", 64'h00_04_04_1F_04_04_00_00);
      add_glyph("-", 64'h00_00_00_1F_00_00_00_00);
      add_glyph("[", 64'h06_04_04_04_04_04_06_00);
      add_glyph("]", 64'h0C_04_04_04_04_04_0C_00);
      add_glyph("(", 64'h02_04_08_08_08_04_02_00);
      add_glyph(")", 64'h08_04_02_02_02_04_08_00);
      add_glyph("{", 64'h03_04_04_08_04_04_03_00);
      add_glyph("}", 64'h18_04_04_02_04_04_18_00);
      add_glyph("0", 64'h0E_11_11_15_11_11_0E_00);
      add_glyph("1", 64'h04_0C_04_04_04_04_0E_00);
      add_glyph("2", 64'h06_09_01_02_04_08_1F_00);
      add_glyph("3", 64'h1F_02_04_02_01_11_0E_00);
      add_glyph("4", 64'h02_06_0A_12_1F_02_02_00);
      add_glyph("5", 64'h1F_10_1E_01_01_11_0E_00);
      add_glyph("6", 64'h06_08_10_1E_11_11_0E_00);
      add_glyph("7", 64'h1F_01_02_04_08_08_08_00);
      add_glyph("8", 64'h0E_11_11_0E_11_11_0E_00);
      add_glyph("9", 64'h0E_11_11_0F_01_02_0C_00);
      add_glyph("A", 64'h0E_11_11_1F_11_11_11_00);
      add_glyph("B", 64'h1E_11_11_1E_11_11_1E_00);
      add_glyph("C", 64'h0E_11_10_10_10_11_0E_00);
      add_glyph("D", 64'h1E_11_11_11_11_11_1E_00);
      add_glyph("E", 64'h1F_10_10_1E_10_10_1F_00);
      add_glyph("F", 64'h1F_10_10_1E_10_10_10_00);
      add_glyph("G", 64'h0E_11_10_17_11_11_0E_00);
      add_glyph("H", 64'h11_11_11_1F_11_11_11_00);
      add_glyph("I", 64'h0E_04_04_04_04_04_0E_00);
      add_glyph("J", 64'h07_02_02_02_02_12_0C_00);
      add_glyph("K", 64'h11_12_14_18_14_12_11_00);
      add_glyph("L", 64'h10_10_10_10_10_10_1F_00);
      add_glyph("M", 64'h11_1B_15_11_11_11_11_00);
      add_glyph("N", 64'h11_19_15_13_11_11_11_00);
      add_glyph("O", 64'h0E_11_11_11_11_11_0E_00);
      add_glyph("P", 64'h1E_11_11_1E_10_10_10_00);
      add_glyph("Q", 64'h0E_11_11_11_15_12_0D_00);
      add_glyph("R", 64'h1E_11_11_1E_14_12_11_00);
      add_glyph("S", 64'h0F_10_10_0E_01_01_1E_00);
      add_glyph("T", 64'h1F_04_04_04_04_04_04_00);
      add_glyph("U", 64'h11_11_11_11_11_11_0E_00);
      add_glyph("V", 64'h11_11_11_11_11_0A_04_00);
      add_glyph("W", 64'h11_11_11_15_15_15_0A_00);
      add_glyph("X", 64'h11_11_0A_04_0A_11_11_00);
      add_glyph("Y", 64'h11_11_11_0A_04_04_04_00);
      add_glyph("Z", 64'h1F_01_02_04_08_10_1F_00);
      add_glyph("a", 64'h00_00_0E_01_0F_11_0F_00);
      add_glyph("b", 64'h10_10_16_19_11_11_1E_00);
      add_glyph("c", 64'h00_00_0E_10_10_11_0E_00);
      add_glyph("d", 64'h01_01_0D_13_11_11_0F_00);
      add_glyph("e", 64'h00_00_0E_11_1F_10_0E_00);
      add_glyph("f", 64'h06_09_08_1C_08_08_08_00);
      add_glyph("g", 64'h00_00_0E_11_11_0F_01_0E);
      add_glyph("h", 64'h10_10_16_19_11_11_11_00);
      add_glyph("i", 64'h04_00_0C_04_04_04_0E_00);
      add_glyph("j", 64'h01_00_03_01_01_01_12_0C);
      add_glyph("k", 64'h08_08_09_0A_0C_0A_09_00);
      add_glyph("l", 64'h0C_04_04_04_04_04_0E_00);
      add_glyph("m", 64'h00_00_1A_15_15_11_11_00);
      add_glyph("n", 64'h00_00_16_19_11_11_11_00);
      add_glyph("o", 64'h00_00_0E_11_11_11_0E_00);
      add_glyph("p", 64'h00_00_1E_11_11_1E_10_10);
      add_glyph("q", 64'h00_00_0D_13_11_0F_01_01);
      add_glyph("r", 64'h00_00_16_19_10_10_10_00);
      add_glyph("s", 64'h00_00_0E_10_0E_01_1E_00);
      add_glyph("t", 64'h08_08_1C_08_08_09_06_00);
      add_glyph("u", 64'h00_00_11_11_11_13_0D_00);
      add_glyph("v", 64'h00_00_11_11_11_0A_04_00);
      add_glyph("w", 64'h00_00_11_11_15_15_0A_00);
      add_glyph("x", 64'h00_00_11_0A_04_0A_11_00);
      add_glyph("y", 64'h00_00_11_11_11_0F_01_0E);
      add_glyph("z", 64'h00_00_1F_02_04_08_1F_00);
   end

   task automatic apply_request(input s58tr_pkg::req_item_type item);
      logic [63:0] rows;
      s58tr_pkg::coord_type step_x, step_y;
      s58tr_pkg::rsp_item_type rect;
      int lit;
      int seen;
      // A dot size of zero behaves as one.
      step_x = {12'd0, ((dot_w == 4'd0) ? 4'd1 : dot_w)} + {12'd0, dot_gx};
      step_y = {12'd0, ((dot_h == 4'd0) ? 4'd1 : dot_h)} + {12'd0, dot_gy};
      if (item.req_type == s58tr_pkg::REQ_START) begin
         line_x = item.origin_x;
         pen_x = item.origin_x;
         pen_y = item.origin_y;
         ink = item.text_color;
      end else if (item.char_code == s58tr_pkg::CHAR_CR
                   || item.char_code == s58tr_pkg::CHAR_LF) begin
         pen_x = line_x;
         pen_y = pen_y + 16'(s58tr_pkg::GLYPH_ROWS * step_y) + {12'd0, glyph_gy};
      end else begin
         rows = font_rows[item.char_code];
         lit = $countones(rows & {8{8'h1F}});
         seen = 0;
         for (int r = 0; r < 8; r++) begin
            for (int c = 0; c < 5; c++) begin
               if (rows[8 * (7 - r) + 4 - c]) begin
                  seen++;
                  rect.rect_x = pen_x + 16'(c) * step_x;
                  rect.rect_y = pen_y + 16'(r) * step_y;
                  rect.rect_color = ink;
                  rect.last_of_char = (seen == lit);
                  awaited_rects.push_back(rect);
               end
            end
         end
         // A blank glyph still moves the cursor.
         pen_x = pen_x + 16'(s58tr_pkg::GLYPH_COLS * step_x) + {12'd0, glyph_gx};
      end
   endtask

   task automatic check_rect(input s58tr_pkg::rsp_item_type got);
      s58tr_pkg::rsp_item_type want;
      if (awaited_rects.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display("unexpected rect: x=%0d y=%0d color=%h last=%b",
                     got.rect_x, got.rect_y, got.rect_color, got.last_of_char);
      end else begin
         want = awaited_rects.pop_front();
         if (got.rect_x !== want.rect_x || got.rect_y !== want.rect_y
             || got.rect_color !== want.rect_color
             || got.last_of_char !== want.last_of_char) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("rect mismatch: exp x=%0d y=%0d c=%h l=%b, got x=%0d y=%0d c=%h l=%b",
                        want.rect_x, want.rect_y, want.rect_color, want.last_of_char,
                        got.rect_x, got.rect_y, got.rect_color, got.last_of_char);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         dot_w = 4'd1;
         dot_h = 4'd1;
         dot_gx = 4'd0;
         dot_gy = 4'd0;
         glyph_gx = 4'd1;
         glyph_gy = 4'd1;
         line_x = '0;
         pen_x = '0;
         pen_y = '0;
         ink = '0;
         awaited_rects.delete();
      end else begin
         if (rsp_valid && !rsp_stall) check_rect(rsp_data);
         if (csr_valid && csr_ready) begin
            case (csr_index)
               s58tr_pkg::CSR_DOT_WIDTH:   dot_w = csr_data;
               s58tr_pkg::CSR_DOT_HEIGHT:  dot_h = csr_data;
               s58tr_pkg::CSR_DOT_GAP_X:   dot_gx = csr_data;
               s58tr_pkg::CSR_DOT_GAP_Y:   dot_gy = csr_data;
               s58tr_pkg::CSR_GLYPH_GAP_X: glyph_gx = csr_data;
               s58tr_pkg::CSR_GLYPH_GAP_Y: glyph_gy = csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) apply_request(req_data);
      end
      rects_pending <= awaited_rects.size();
      failures <= mismatch_count;
   end

endmodule

// File: test/tb_scaled_5x8_text_renderer.sv
// Testbench top for the scaled 5x8 text renderer: stimulus, pacing and verdict.
module tb_scaled_5x8_text_renderer;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int SETTLE_CYCLES = 64;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int RANDOM_PHASES = 8;
   localparam int ITEMS_PER_PHASE = 50;
   localparam logic [2:0] CSR_UNMAPPED = 3'd6;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   s58tr_pkg::req_item_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall;
   s58tr_pkg::rsp_item_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [2:0] csr_index = s58tr_pkg::CSR_DOT_WIDTH;
   logic [3:0] csr_data = 4'd0;

   logic pace_stall = 1'b0;
   logic hold_off = 1'b0;
   bit no_idle = 1'b0;
   bit hold_request = 1'b0;
   int cycle_count = 0;
   int pending;
   int failures;

   assign rsp_stall = pace_stall | hold_off;

   scaled_5x8_text_renderer dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   s58tr_rect_checker rect_check (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .rects_pending(pending),
      .failures(failures)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Unless no_idle is set, the receiver waits a random number of cycles before taking each rectangle.
   initial begin : receiver
      int wait_cycles;
      forever begin
         wait_cycles = no_idle ? 0 : int'($urandom_range(0, 8));
         if (wait_cycles > 0) begin
            pace_stall <= 1'b1;
            repeat (wait_cycles) @(posedge clock);
         end
         pace_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   // One long hold-off so that the block backs up and stalls its input.
   initial begin : long_hold
      wait (hold_request);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_OFF_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   function automatic s58tr_pkg::req_item_type make_start(input logic [15:0] x,
                                                          input logic [15:0] y,
                                                          input logic [31:0] color);
      s58tr_pkg::req_item_type item;
      item.req_type = s58tr_pkg::REQ_START;
      item.origin_x = x;
      item.origin_y = y;
      item.text_color = color;
      item.char_code = 8'($urandom);
      return item;
   endfunction

   function automatic s58tr_pkg::req_item_type make_char(input logic [7:0] code);
      s58tr_pkg::req_item_type item;
      item.req_type = s58tr_pkg::REQ_CHAR;
      item.origin_x = 16'($urandom);
      item.origin_y = 16'($urandom);
      item.text_color = $urandom;
      item.char_code = code;
      return item;
   endfunction

   function automatic s58tr_pkg::req_item_type random_item();
      int pick;
      pick = int'($urandom_range(0, 99));
      if (pick < 5) return make_start(16'($urandom), 16'($urandom), $urandom);
      else if (pick < 12) return make_char(pick[0] ? s58tr_pkg::CHAR_CR : s58tr_pkg::CHAR_LF);
      else if (pick < 20) return make_char(8'($urandom));
      else return make_char(8'($urandom_range(32, 126)));
   endfunction

   task automatic send_item(input s58tr_pkg::req_item_type item);
      int gap;
      gap = no_idle ? 0 : int'($urandom_range(0, 8));
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!(req_valid && !req_stall));
   endtask

   task automatic csr_write(input logic [2:0] index, input logic [3:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock); while (!(csr_valid && csr_ready));
   endtask

   task automatic program_regs(input logic [3:0] w, input logic [3:0] h,
                               input logic [3:0] gx, input logic [3:0] gy,
                               input logic [3:0] ggx, input logic [3:0] ggy);
      csr_write(s58tr_pkg::CSR_DOT_WIDTH, w);
      csr_write(s58tr_pkg::CSR_DOT_HEIGHT, h);
      csr_write(s58tr_pkg::CSR_DOT_GAP_X, gx);
      csr_write(s58tr_pkg::CSR_DOT_GAP_Y, gy);
      csr_write(s58tr_pkg::CSR_GLYPH_GAP_X, ggx);
      csr_write(s58tr_pkg::CSR_GLYPH_GAP_Y, ggy);
      // A write past the last register must leave every setting alone.
      csr_write(CSR_UNMAPPED | 3'($urandom_range(0, 1)), 4'($urandom));
      csr_valid <= 1'b0;
   endtask

   // Waits until every predicted rectangle has arrived, then lets a blank glyph finish.
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin : stimulus
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Reset settings; the first character is drawn from the cleared cursor.
      send_item(make_char("A"));
      send_item(make_start(16'h7FFF, 16'h7FFF, 32'hFFFF_FFFF));
      send_item(make_char("#"));
      send_item(make_char(s58tr_pkg::CHAR_CR));
      send_item(make_char("j"));
      send_item(make_start(16'h8000, 16'h8000, 32'h0000_0000));
      send_item(make_char("@"));
      send_item(make_char(" "));
      send_item(make_char(s58tr_pkg::CHAR_LF));
      send_item(make_char(8'h00));
      send_item(make_char(8'hFF));
      send_item(make_char(8'h60));
      send_item(make_char("?"));
      send_item(make_char("*"));
      settle();

      program_regs(4'hF, 4'hF, 4'hF, 4'hF, 4'hF, 4'hF);
      send_item(make_start(16'h8000, 16'h7000, 32'hAA55_AA55));
      send_item(make_char("W"));
      send_item(make_char("M"));
      send_item(make_char(s58tr_pkg::CHAR_CR));
      send_item(make_char("g"));
      settle();

      // Zero dot sizes behave as one.
      program_regs(4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0);
      send_item(make_start(16'd100, 16'hFF9C, 32'h1234_5678));
      send_item(make_char("8"));
      send_item(make_char(s58tr_pkg::CHAR_LF));
      send_item(make_char("%"));
      send_item(make_char("~"));
      settle();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         program_regs(4'($urandom), 4'($urandom), 4'($urandom),
                      4'($urandom), 4'($urandom), 4'($urandom));
         no_idle = (p % 4 == 3);
         if (p == 1) hold_request = 1'b1;
         send_item(make_start(16'($urandom), 16'($urandom), $urandom));
         for (int i = 1; i < ITEMS_PER_PHASE; i++) send_item(random_item());
         settle();
      end

      if (failures == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/s58tr_pkg.sv
rtl/s58tr_datapath.sv
rtl/s58tr_ctrl.sv
rtl/scaled_5x8_text_renderer.sv
test/s58tr_rect_checker.sv
test/tb_scaled_5x8_text_renderer.sv
